// File: src/cpr_pkg.sv
// Shared types, widths and arithmetic helpers for the complex plane rotation block.
// No dependencies; imported by cpr_term, complex_plane_rotation and the bench.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    localparam int DataW  = 32;              // one Q2.30 value
    localparam int ProdW  = 2 * DataW;       // full Q4.60 product
    localparam int FracW  = 30;              // fractional bits
    localparam int RndW   = ProdW - FracW;   // rounded product, holds +/-2^32
    localparam int SumW   = RndW + 1;        // sum of three rounded products
    localparam int TdataW = 4 * DataW;       // four parts, already whole bytes
    localparam int AddrW  = 2;

    typedef logic signed [DataW-1:0] word_t;
    typedef logic signed [ProdW-1:0] prod_t;
    typedef logic signed [RndW-1:0]  rnd_t;
    typedef logic signed [SumW-1:0]  sum_t;

    // register indexes on the configuration port
    typedef enum logic [AddrW-1:0] {
        REG_COS    = 2'd0,
        REG_SIN_RE = 2'd1,
        REG_SIN_IM = 2'd2
    } reg_idx_t;

    localparam word_t CosReset = word_t'(32'sd1073741824);
    localparam prod_t HalfLsb  = prod_t'(64'sd536870912);
    localparam sum_t  SatMax   = sum_t'(35'sd2147483647);
    localparam sum_t  SatMin   = -sum_t'(35'sd2147483648);

    // pipeline load strobes, one per stage
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

    // floor((p + 2^29) / 2^30): round to nearest, ties toward plus infinity
    function automatic rnd_t round_prod(input prod_t p);
        prod_t t;
        t = p + HalfLsb;
        return t[ProdW-1:FracW];
    endfunction

    function automatic word_t sat_word(input sum_t s);
        word_t w;
        if (s > SatMax) begin
            w = word_t'(SatMax[DataW-1:0]);
        end else if (s < SatMin) begin
            w = word_t'(SatMin[DataW-1:0]);
        end else begin
            w = s[DataW-1:0];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/cpr_term.sv
// One output part: three Q2.30 products, each rounded, summed with signs and saturated.
// Three register stages (multiply, round, sum/saturate); depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_term (
    input  wire                 aclk,
    input  cpr_pkg::pipe_ctl_t  ctl,
    input  cpr_pkg::word_t      a0,
    input  cpr_pkg::word_t      b0,
    input  cpr_pkg::word_t      a1,
    input  cpr_pkg::word_t      b1,
    input  cpr_pkg::word_t      a2,
    input  cpr_pkg::word_t      b2,
    input  wire                 neg1,
    input  wire                 neg2,
    output cpr_pkg::word_t      result
);
    import cpr_pkg::*;

    prod_t p0_reg, p1_reg, p2_reg;
    rnd_t  r0_reg, r1_reg, r2_reg;
    word_t res_reg;
    sum_t  t1, t2, sum_next;

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            p0_reg <= prod_t'(a0) * prod_t'(b0);
            p1_reg <= prod_t'(a1) * prod_t'(b1);
            p2_reg <= prod_t'(a2) * prod_t'(b2);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            r0_reg <= round_prod(p0_reg);
            r1_reg <= round_prod(p1_reg);
            r2_reg <= round_prod(p2_reg);
        end
    end

    always_comb begin
        t1 = neg1 ? -sum_t'(r1_reg) : sum_t'(r1_reg);
        t2 = neg2 ? -sum_t'(r2_reg) : sum_t'(r2_reg);
        sum_next = sum_t'(r0_reg) + t1 + t2;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            res_reg <= sat_word(sum_next);
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// File: src/complex_plane_rotation.sv
// Top level of the complex plane rotation: stream ports, configuration registers,
// pipeline control and four cpr_term datapaths; depends on cpr_pkg and cpr_term.
`timescale 1ns / 1ps
`default_nettype none

// Rotates one pair of complex Q2.30 elements per transfer: x' = c*x + s*y and
// y' = c*y - conj(s)*x, every product rounded to nearest on its own and each sum
// saturated to 32 bits. The block takes one pair every cycle unless the pipeline holds; a
// result passes through the multiply, round and sum-and-saturate stages, and the
// pipeline only holds when the output register is full and not taken. tlast is carried
// along with its pair. Write c, Re(s) and Im(s) only while no pair is in flight.
module complex_plane_rotation (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration
    input  wire                          cfg_wr_en,
    input  wire [cpr_pkg::AddrW-1:0]     cfg_addr,
    input  wire [cpr_pkg::DataW-1:0]     cfg_wdata,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [cpr_pkg::TdataW-1:0]    s_tdata,   // x_re, x_im, y_re, y_im
    input  wire                          s_tlast,   // in_last
    // result stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [cpr_pkg::TdataW-1:0]   m_tdata,   // xo_re, xo_im, yo_re, yo_im
    output logic                         m_tlast    // out_last
);
    import cpr_pkg::*;

    word_t cos_reg, sin_re_reg, sin_im_reg;
    logic  v1_reg, v2_reg, v3_reg;
    logic  l1_reg, l2_reg, l3_reg;
    logic  rdy1, rdy2, rdy3;
    pipe_ctl_t ctl;
    word_t x_re, x_im, y_re, y_im;
    word_t xo_re, xo_im, yo_re, yo_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= CosReset;
            sin_re_reg <= '0;
            sin_im_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_COS:    cos_reg    <= cfg_wdata;
                REG_SIN_RE: sin_re_reg <= cfg_wdata;
                REG_SIN_IM: sin_im_reg <= cfg_wdata;
                default:    ;   // unused index: drop the write
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances
    assign rdy3 = !v3_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctl.ld1 = s_tvalid && rdy1;
    assign ctl.ld2 = v1_reg && rdy2;
    assign ctl.ld3 = v2_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) l1_reg <= s_tlast;
        if (ctl.ld2) l2_reg <= l1_reg;
        if (ctl.ld3) l3_reg <= l2_reg;
    end

    assign x_re = s_tdata[DataW-1:0];
    assign x_im = s_tdata[2*DataW-1:DataW];
    assign y_re = s_tdata[3*DataW-1:2*DataW];
    assign y_im = s_tdata[4*DataW-1:3*DataW];

    // x' real: c*xr + sr*yr - si*yi
    cpr_term u_xo_re (
        .aclk(aclk), .ctl(ctl),
        .a0(cos_reg), .b0(x_re), .a1(sin_re_reg), .b1(y_re), .a2(sin_im_reg), .b2(y_im),
        .neg1(1'b0), .neg2(1'b1), .result(xo_re)
    );

    // x' imag: c*xi + sr*yi + si*yr
    cpr_term u_xo_im (
        .aclk(aclk), .ctl(ctl),
        .a0(cos_reg), .b0(x_im), .a1(sin_re_reg), .b1(y_im), .a2(sin_im_reg), .b2(y_re),
        .neg1(1'b0), .neg2(1'b0), .result(xo_im)
    );

    // y' real: c*yr - sr*xr - si*xi
    cpr_term u_yo_re (
        .aclk(aclk), .ctl(ctl),
        .a0(cos_reg), .b0(y_re), .a1(sin_re_reg), .b1(x_re), .a2(sin_im_reg), .b2(x_im),
        .neg1(1'b1), .neg2(1'b1), .result(yo_re)
    );

    // y' imag: c*yi - sr*xi + si*xr
    cpr_term u_yo_im (
        .aclk(aclk), .ctl(ctl),
        .a0(cos_reg), .b0(y_im), .a1(sin_re_reg), .b1(x_im), .a2(sin_im_reg), .b2(x_re),
        .neg1(1'b1), .neg2(1'b0), .result(yo_im)
    );

    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign m_tlast  = l3_reg;
    assign m_tdata  = {yo_im, yo_re, xo_im, xo_re};

    // input is refused only when every stage is full and the output is blocked
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer did not enter the first stage");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !m_tready) |=> (v3_reg && $stable(xo_re) && $stable(yo_im)))
        else $error("waiting result lost or changed");

    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("second stage advanced without filling the output");

endmodule

`default_nettype wire

// File: bench/tb_complex_plane_rotation.sv
// Self-checking bench for complex_plane_rotation: streams complex element pairs through
// the block and checks every rotated pair against a fixed-point predictor in this file.
// Depends on cpr_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_complex_plane_rotation;
    import cpr_pkg::*;

    localparam int CycleLimit = 100000;
    localparam int PhaseItems = 105;
    localparam int HoldCycles = 250;
    localparam int MaxReports = 10;
    localparam logic [AddrW-1:0] RegUnused = 2'd3;   // past the last register

    localparam word_t WMax  = 32'sh7fffffff;
    localparam word_t WMin  = 32'sh80000000;
    localparam word_t WHalf = 32'sh20000000;          // 0.5 in Q2.30

    typedef struct packed {
        word_t x_re;
        word_t x_im;
        word_t y_re;
        word_t y_im;
        logic  last;
    } pair_t;

    typedef struct packed {
        word_t xo_re;
        word_t xo_im;
        word_t yo_re;
        word_t yo_im;
        logic  last;
    } rot_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [AddrW-1:0]  cfg_addr = '0;
    logic [DataW-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [TdataW-1:0] s_tdata = '0;   // x_re, x_im, y_re, y_im
    logic              s_tlast = 1'b0; // in_last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TdataW-1:0] m_tdata;        // xo_re, xo_im, yo_re, yo_im
    logic              m_tlast;        // out_last

    complex_plane_rotation uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register copies used for prediction
    word_t cos_c = CosReset;
    word_t sin_r = '0;
    word_t sin_i = '0;

    pair_t pend_pairs[$];
    rot_t  rotated_q[$];
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_mismatch = 0;
    int    n_settings = 1;
    int    cycle_cnt = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    bit    quiet = 1'b0;

    // Q2.30 product, rounded to nearest with ties upward
    function automatic longint round_mul(input word_t a, input word_t b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd536870912;
        return p >>> FracW;
    endfunction

    function automatic word_t clamp_word(input longint s);
        if (s > 64'sd2147483647) begin
            return WMax;
        end else if (s < -64'sd2147483648) begin
            return WMin;
        end
        return word_t'(s[DataW-1:0]);
    endfunction

    function automatic rot_t rotate_pair(input pair_t p);
        rot_t r;
        r.xo_re = clamp_word(round_mul(cos_c, p.x_re) + round_mul(sin_r, p.y_re)
                             - round_mul(sin_i, p.y_im));
        r.xo_im = clamp_word(round_mul(cos_c, p.x_im) + round_mul(sin_r, p.y_im)
                             + round_mul(sin_i, p.y_re));
        r.yo_re = clamp_word(round_mul(cos_c, p.y_re) - round_mul(sin_r, p.x_re)
                             - round_mul(sin_i, p.x_im));
        r.yo_im = clamp_word(round_mul(cos_c, p.y_im) - round_mul(sin_r, p.x_im)
                             + round_mul(sin_i, p.x_re));
        r.last = p.last;
        return r;
    endfunction

    // mostly full-range values, with extremes, tiny values and values near +/-1.0
    function automatic word_t rand_word();
        case ($urandom_range(7))
            0: return WMax;
            1: return WMin;
            2: return word_t'($urandom_range(8)) - 4;
            3: return word_t'($urandom_range(2047)) + ($urandom_range(1) ? 32'sh3ffffc00
                                                                         : 32'shc0000000);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic pair_t make_pair(input word_t xr, input word_t xi, input word_t yr,
                                        input word_t yi, input logic lst);
        pair_t p;
        p.x_re = xr;
        p.x_im = xi;
        p.y_re = yr;
        p.y_im = yi;
        p.last = lst;
        return p;
    endfunction

    task automatic write_reg(input logic [AddrW-1:0] idx, input word_t val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COS:    cos_c = val;
            REG_SIN_RE: sin_r = val;
            REG_SIN_IM: sin_i = val;
            default: ;
        endcase
    endtask

    task automatic set_rotation(input word_t c, input word_t sr, input word_t si);
        write_reg(REG_COS, c);
        write_reg(REG_SIN_RE, sr);
        write_reg(REG_SIN_IM, si);
        n_settings++;
    endtask

    // hold the sender until every expected pair is back and the pipeline is empty
    task automatic drain();
        while (pend_pairs.size() != 0 || rotated_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic check_word(input string name, input word_t want, input word_t got);
        if (want !== got) begin
            n_mismatch++;
            if (n_mismatch <= MaxReports) begin
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         name, n_checked, want, got);
            end
        end
    endtask

    // sender: offer the head of the pending queue, idle at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rotated_q.push_back(rotate_pair(pend_pairs.pop_front()));
                n_sent <= n_sent + 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer
            end else if (pend_pairs.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pend_pairs[0].y_im, pend_pairs[0].y_re,
                             pend_pairs[0].x_im, pend_pairs[0].x_re};
                s_tlast  <= pend_pairs[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && n_sent >= 300 && pend_pairs.size() > 40) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet || $urandom_range(99) >= 23;
        end
    end

    always @(posedge aclk) begin
        rot_t got;
        rot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tlast};
            if (rotated_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MaxReports) begin
                    $display("unexpected result transfer: %h last %b", m_tdata, m_tlast);
                end
            end else begin
                want = rotated_q.pop_front();
                check_word("xo_re", want.xo_re, got.xo_re);
                check_word("xo_im", want.xo_im, got.xo_im);
                check_word("yo_re", want.yo_re, got.yo_re);
                check_word("yo_im", want.yo_im, got.yo_im);
                check_word("out_last", word_t'(want.last), word_t'(got.last));
            end
            n_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, rotated_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // an out-of-range index must leave the reset rotation (identity) in place
        write_reg(RegUnused, word_t'($urandom));
        @(negedge aclk);
        pend_pairs.push_back(make_pair('0, '0, '0, '0, 1'b0));
        pend_pairs.push_back(make_pair(WMax, WMax, WMax, WMax, 1'b1));
        pend_pairs.push_back(make_pair(WMin, WMin, WMin, WMin, 1'b0));
        pend_pairs.push_back(make_pair(32'sd1, -32'sd1, WMax, WMin, 1'b1));
        drain();

        // extreme coefficients: saturation both ways
        set_rotation(WMax, WMax, WMin);
        pend_pairs.push_back(make_pair(WMax, WMax, WMax, WMax, 1'b0));
        pend_pairs.push_back(make_pair(WMin, WMin, WMin, WMin, 1'b0));
        pend_pairs.push_back(make_pair(WMax, WMin, WMin, WMax, 1'b1));
        pend_pairs.push_back(make_pair(WMin, WMin, WMax, WMax, 1'b0));
        drain();

        // half-LSB products: ties round upward
        set_rotation(WHalf, -WHalf, 32'sd1);
        pend_pairs.push_back(make_pair(32'sd1, -32'sd1, 32'sd1, -32'sd1, 1'b0));
        pend_pairs.push_back(make_pair(32'sd3, -32'sd3, -32'sd3, 32'sd3, 1'b1));
        pend_pairs.push_back(make_pair(32'sd2, 32'sd0, 32'sd0, -32'sd2, 1'b0));
        pend_pairs.push_back(make_pair(rand_word(), rand_word(), rand_word(), rand_word(),
                                       1'b1));
        drain();

        // most negative cosine: min*min overflows a single product
        set_rotation(WMin, '0, WMax);
        pend_pairs.push_back(make_pair(WMin, WMax, WMin, WMax, 1'b0));
        pend_pairs.push_back(make_pair(WMax, WMin, WMax, WMin, 1'b1));
        pend_pairs.push_back(make_pair(WMin, WMin, WMax, WMax, 1'b0));
        pend_pairs.push_back(make_pair(-32'sd1, 32'sd1, 32'sd0, WMin, 1'b1));
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_rotation(WMin, WMin, WMin);
                1: set_rotation(WMax, WMax, WMax);
                2: set_rotation(word_t'($urandom_range(32'h40000000)),
                                word_t'($urandom_range(32'h5a827999)) - 32'sh2d413ccc,
                                word_t'($urandom_range(32'h5a827999)) - 32'sh2d413ccc);
                default: set_rotation(rand_word(), rand_word(), rand_word());
            endcase
            if (ph == 5) begin
                write_reg(RegUnused, word_t'($urandom));
            end
            quiet = (ph == 3);
            @(negedge aclk);
            for (k = 0; k < PhaseItems; k++) begin
                pend_pairs.push_back(make_pair(rand_word(), rand_word(), rand_word(),
                                               rand_word(), $urandom_range(7) == 0));
            end
            drain();
        end
        quiet = 1'b0;

        repeat (20) @(posedge aclk);
        if (rotated_q.size() != 0) begin
            n_mismatch++;
            $display("%0d expected results never arrived", rotated_q.size());
        end
        $display("%0d element pairs rotated and checked under %0d rotation settings,",
                 n_checked, n_settings);
        $display("covering extreme operands, rounding ties, saturation and back-pressure");
        if (n_mismatch == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/cpr_pkg.sv
src/cpr_term.sv
src/complex_plane_rotation.sv
bench/tb_complex_plane_rotation.sv
